// ===== hw/rtl/preemptive_priority_scheduler_macros.svh =====
// Assertion macros shared by the checker
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// implication checked on every clock edge outside reset
`define PPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pps check failed");

// next-cycle implication
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pps check failed");

`endif

// ===== hw/rtl/pps_pkg.sv =====
package pps_pkg;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_ROUND  = 2'd2;

	localparam logic [1:0] ST_EMPTY   = 2'd0;
	localparam logic [1:0] ST_PENDING = 2'd1;
	localparam logic [1:0] ST_READY   = 2'd2;
	localparam logic [1:0] ST_DONE    = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  slot;
		logic [7:0]  prio;
		logic [23:0] arrival;
		logic [15:0] duration;
	} in_item_t;

	typedef struct packed {
		logic [31:0] now;
		logic        ran_valid;
		logic [3:0]  ran_slot;
		logic [6:0]  lines_run;
		logic        completed;
		logic [31:0] turnaround;
		logic [31:0] waiting;
		logic        all_done;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic do_load;
		logic do_append;
		logic scan_clr;     // start slot scan
		logic scan_admit;   // admit arrivals during admit pass
		logic scan_step;    // examine current scan slot
		logic run_fetch;    // issue instruction read
		logic run_exec;     // add fetched duration, admit arrivals
		logic finish;       // build result
		logic jump;         // clock to next arrival
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;
		logic found;
		logic any_pending;
		logic lines_left;
		logic newcomer;
	} sts_t;

endpackage

// ===== hw/rtl/pps_datapath.sv =====
module pps_datapath #(
	parameter int MAX_SLOTS = 16,
	parameter int MAX_LINES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pps_pkg::in_item_t item,
	input  pps_pkg::cmd_t     cmd,
	output pps_pkg::sts_t     sts,
	output pps_pkg::out_item_t result
);
	import pps_pkg::*;

	localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int LW = $clog2(MAX_LINES + 1);
	localparam int AW = $clog2(MAX_SLOTS * MAX_LINES) > 0 ? $clog2(MAX_SLOTS * MAX_LINES) : 1;

	logic [31:0]   clock_q;
	logic [1:0]    status_q [MAX_SLOTS];
	logic [7:0]    prio_q   [MAX_SLOTS];
	logic [23:0]   arr_q    [MAX_SLOTS];
	logic [LW-1:0] len_q    [MAX_SLOTS];
	logic [LW-1:0] next_q   [MAX_SLOTS];
	logic [31:0]   total_q  [MAX_SLOTS];
	logic [15:0]   imem [MAX_SLOTS * MAX_LINES];
	logic [15:0]   rdata_q;

	logic [SW-1:0] scan_q, best_q;
	logic          found_q, pend_q, new_q;
	logic [23:0]   next_arr_q;
	logic [LW-1:0] count_q;

	logic          in_range;
	logic [SW-1:0] islot;
	logic [31:0]   clk_plus;
	logic          any_due;
	logic          better;
	logic [31:0]   ta;
	logic          others_live;
	out_item_t     res_d;

	assign in_range = 32'(item.slot) < 32'(MAX_SLOTS);
	assign islot    = SW'(item.slot);
	assign clk_plus = clock_q + 32'(rdata_q);

	always_comb begin
		any_due = 1'b0;
		for (int s = 0; s < MAX_SLOTS; s++)
			if (status_q[s] == ST_PENDING && 32'(arr_q[s]) <= clk_plus)
				any_due = 1'b1;
	end

	assign better = !found_q || prio_q[scan_q] < prio_q[best_q] ||
		(prio_q[scan_q] == prio_q[best_q] && arr_q[scan_q] < arr_q[best_q]);
	assign ta = clock_q - 32'(arr_q[best_q]);

	always_comb begin
		sts             = '0;
		sts.scan_last   = 32'(scan_q) == 32'(MAX_SLOTS - 1);
		sts.found       = found_q;
		sts.any_pending = pend_q;
		sts.lines_left  = next_q[best_q] < len_q[best_q];
		sts.newcomer    = new_q;
	end

	// any pending or ready slot other than the dispatched one
	always_comb begin
		others_live = 1'b0;
		for (int s = 0; s < MAX_SLOTS; s++)
			if ((status_q[s] == ST_READY || status_q[s] == ST_PENDING) &&
				!(found_q && SW'(s) == best_q))
				others_live = 1'b1;
	end

	always_comb begin
		res_d     = '0;
		res_d.now = cmd.jump ? 32'(next_arr_q) : clock_q;
		if (found_q) begin
			res_d.ran_valid = 1'b1;
			res_d.ran_slot  = 4'(best_q);
			res_d.lines_run = 7'(count_q);
			if (!sts.lines_left) begin
				res_d.completed  = 1'b1;
				res_d.turnaround = ta;
				res_d.waiting    = ta - total_q[best_q];
			end
		end
		res_d.all_done = !(found_q && sts.lines_left) && !others_live;
	end

	always_ff @(posedge clk) begin
		if (cmd.do_append && in_range && len_q[islot] < LW'(MAX_LINES))
			imem[AW'(32'(islot) * MAX_LINES + 32'(len_q[islot]))] <= item.duration;
		if (cmd.run_fetch)
			rdata_q <= imem[AW'(32'(best_q) * MAX_LINES + 32'(next_q[best_q]))];
	end

	always_ff @(posedge clk) begin
		if (cmd.do_load && in_range) begin
			prio_q[islot] <= item.prio;
			arr_q[islot]  <= item.arrival;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
			for (int s = 0; s < MAX_SLOTS; s++) begin
				status_q[s] <= ST_EMPTY;
				len_q[s]    <= '0;
				next_q[s]   <= '0;
				total_q[s]  <= '0;
			end
			scan_q <= '0; best_q <= '0; found_q <= 1'b0; pend_q <= 1'b0;
			new_q <= 1'b0; next_arr_q <= '0; count_q <= '0;
			result <= '0;
		end else begin
			if (cmd.do_load && in_range) begin
				status_q[islot] <= ST_PENDING;
				len_q[islot]    <= '0;
				next_q[islot]   <= '0;
				total_q[islot]  <= '0;
			end
			if (cmd.do_append && in_range && len_q[islot] < LW'(MAX_LINES) &&
				(status_q[islot] == ST_PENDING || status_q[islot] == ST_READY)) begin
				len_q[islot]   <= len_q[islot] + 1'b1;
				total_q[islot] <= total_q[islot] + 32'(item.duration);
			end
			if (cmd.scan_clr) begin
				scan_q <= '0; found_q <= 1'b0; pend_q <= 1'b0;
				best_q <= '0; new_q <= 1'b0; count_q <= '0;
			end
			if (cmd.scan_admit) begin
				// admit pass: one slot per cycle
				if (status_q[scan_q] == ST_PENDING && 32'(arr_q[scan_q]) <= clock_q)
					status_q[scan_q] <= ST_READY;
				scan_q <= sts.scan_last ? '0 : scan_q + 1'b1;
			end
			if (cmd.scan_step) begin
				if (status_q[scan_q] == ST_READY && better) begin
					best_q <= scan_q; found_q <= 1'b1;
				end
				if (status_q[scan_q] == ST_PENDING &&
					(!pend_q || arr_q[scan_q] < next_arr_q)) begin
					next_arr_q <= arr_q[scan_q]; pend_q <= 1'b1;
				end
				scan_q <= sts.scan_last ? '0 : scan_q + 1'b1;
			end
			if (cmd.run_exec) begin
				clock_q <= clk_plus;
				next_q[best_q] <= next_q[best_q] + 1'b1;
				count_q <= count_q + 1'b1;
				for (int s = 0; s < MAX_SLOTS; s++)
					if (status_q[s] == ST_PENDING && 32'(arr_q[s]) <= clk_plus)
						status_q[s] <= ST_READY;
				new_q <= any_due;
			end
			if (cmd.jump)
				clock_q <= 32'(next_arr_q);
			if (cmd.finish) begin
				result <= res_d;
				if (found_q && !sts.lines_left)
					status_q[best_q] <= ST_DONE;
			end
		end
	end

endmodule

// ===== hw/rtl/pps_ctrl.sv =====
module pps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        action,
	output logic              out_valid,
	input  logic              out_stall,
	input  pps_pkg::sts_t     sts,
	output pps_pkg::cmd_t     cmd
);
	import pps_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_ADMIT, S_SELECT, S_FETCH, S_EXEC, S_CHECK, S_FINISH, S_OUT
	} state_t;

	state_t state_q;
	logic   take;

	assign in_stall = !(state_q == S_IDLE || (state_q == S_OUT && !out_stall));
	assign take     = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		cmd.do_load    = take && action == ACT_LOAD;
		cmd.do_append  = take && action == ACT_APPEND;
		cmd.scan_clr   = take && action == ACT_ROUND;
		cmd.scan_admit = state_q == S_ADMIT;
		cmd.scan_step  = state_q == S_SELECT;
		cmd.run_fetch  = state_q == S_FETCH;
		cmd.run_exec   = state_q == S_EXEC;
		cmd.jump       = state_q == S_FINISH && !sts.found && sts.any_pending;
		cmd.finish     = state_q == S_FINISH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take && action == ACT_ROUND)
						state_q <= S_ADMIT;
				end
				S_OUT: begin
					// result leaves; a new round may start in the same cycle
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= (take && action == ACT_ROUND) ? S_ADMIT : S_IDLE;
					end
				end
				S_ADMIT:  if (sts.scan_last) state_q <= S_SELECT;
				S_SELECT: if (sts.scan_last) state_q <= S_CHECK;
				S_CHECK: begin
					if (sts.found && sts.lines_left && !sts.newcomer)
						state_q <= S_FETCH;
					else
						state_q <= S_FINISH;
				end
				S_FETCH:  state_q <= S_EXEC;
				S_EXEC:   state_q <= S_CHECK;
				S_FINISH: begin
					state_q   <= S_OUT;
					out_valid <= 1'b1;
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/preemptive_priority_scheduler.sv =====
// channel | direction | handshake        | payload
// in      | input     | in_valid/in_stall   | in_item_t
// out     | output    | out_valid/out_stall | out_item_t
// Load and append items leave the block idle. A round scans all slots to admit,
// again to select, then runs each instruction as read, add and check, paced by
// the single instruction memory port. The result is held in a register; the
// next item is taken in the cycle the result leaves. Async reset empties all slots.
module preemptive_priority_scheduler #(
	parameter int MAX_SLOTS = 16,
	parameter int MAX_LINES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pps_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output pps_pkg::out_item_t out_item
);
	import pps_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pps_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .action(in_item.action),
		.out_valid, .out_stall, .sts, .cmd
	);

	pps_datapath #(.MAX_SLOTS(MAX_SLOTS), .MAX_LINES(MAX_LINES)) u_dp (
		.clk, .arst_n, .item(in_item), .cmd, .sts, .result(out_item)
	);

endmodule

// ===== hw/rtl/pps_checker.sv =====
module pps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input pps_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_stall,
	input pps_pkg::out_item_t out_item
);
	import pps_pkg::*;
	`include "preemptive_priority_scheduler_macros.svh"

	`PPS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item))
	`PPS_ASSERT_IMP(a_busy_stall, clk, arst_n, out_valid && out_stall, in_stall)
	`PPS_ASSERT_IMP(a_idle_slot, clk, arst_n, out_valid && !out_item.ran_valid, out_item.ran_slot == 4'd0 && out_item.lines_run == 7'd0)
	`PPS_ASSERT_IMP(a_cmp_run, clk, arst_n, out_valid && out_item.completed, out_item.ran_valid)

endmodule

bind preemptive_priority_scheduler pps_checker u_chk (.*);

// ===== sim/preemptive_priority_scheduler_test.sv =====
`timescale 1ns / 100ps

module preemptive_priority_scheduler_test;
	import pps_pkg::*;

	localparam int N_SLOTS = 16;
	localparam int N_LINES = 64;
	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int IN_W = $bits(in_item_t);

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;

	preemptive_priority_scheduler u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	// shadow of the scheduler state
	logic [31:0] sim_clock;
	logic [1:0]  proc_status [N_SLOTS];
	logic [7:0]  proc_prio [N_SLOTS];
	logic [23:0] proc_arrival [N_SLOTS];
	int          proc_len [N_SLOTS];
	int          proc_pc [N_SLOTS];
	logic [31:0] proc_busy [N_SLOTS];
	logic [15:0] proc_code [N_SLOTS][N_LINES];

	out_item_t round_results [$];
	int errors;
	bit gaps_on;
	longint cycle_count;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout at %0t", $time);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic bit admit_due();
		bit any;
		any = 0;
		for (int s = 0; s < N_SLOTS; s++)
			if (proc_status[s] == ST_PENDING && 32'(proc_arrival[s]) <= sim_clock) begin
				proc_status[s] = ST_READY;
				any = 1;
			end
		return any;
	endfunction

	function automatic void schedule_item(in_item_t it);
		out_item_t r;
		int best;
		bit found, arrived, any;
		logic [31:0] next_arr;
		case (it.action)
			ACT_LOAD: begin
				proc_status[it.slot] = ST_PENDING;
				proc_prio[it.slot] = it.prio;
				proc_arrival[it.slot] = it.arrival;
				proc_len[it.slot] = 0;
				proc_pc[it.slot] = 0;
				proc_busy[it.slot] = 0;
			end
			ACT_APPEND: begin
				if ((proc_status[it.slot] == ST_PENDING || proc_status[it.slot] == ST_READY)
						&& proc_len[it.slot] < N_LINES) begin
					proc_code[it.slot][proc_len[it.slot]] = it.duration;
					proc_len[it.slot]++;
					proc_busy[it.slot] += it.duration;
				end
			end
			ACT_ROUND: begin
				r = '0;
				void'(admit_due());
				found = 0;
				best = 0;
				for (int s = 0; s < N_SLOTS; s++) begin
					if (proc_status[s] != ST_READY)
						continue;
					if (!found || proc_prio[s] < proc_prio[best] ||
							(proc_prio[s] == proc_prio[best]
							&& proc_arrival[s] < proc_arrival[best])) begin
						best = s;
						found = 1;
					end
				end
				if (found) begin
					arrived = 0;
					while (proc_pc[best] < proc_len[best] && !arrived) begin
						sim_clock += proc_code[best][proc_pc[best]];
						proc_pc[best]++;
						r.lines_run++;
						if (admit_due())
							arrived = 1;
					end
					r.ran_valid = 1;
					r.ran_slot = best[3:0];
					if (proc_pc[best] >= proc_len[best]) begin
						proc_status[best] = ST_DONE;
						r.completed = 1;
						r.turnaround = sim_clock - 32'(proc_arrival[best]);
						r.waiting = r.turnaround - proc_busy[best];
					end
				end else begin
					any = 0;
					next_arr = 0;
					for (int s = 0; s < N_SLOTS; s++)
						if (proc_status[s] == ST_PENDING
								&& (!any || 32'(proc_arrival[s]) < next_arr)) begin
							next_arr = 32'(proc_arrival[s]);
							any = 1;
						end
					if (any)
						sim_clock = next_arr;
				end
				r.now = sim_clock;
				r.all_done = 1;
				for (int s = 0; s < N_SLOTS; s++)
					if (proc_status[s] == ST_PENDING || proc_status[s] == ST_READY)
						r.all_done = 0;
				round_results = {round_results, r};
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(in_item_t it);
		while (gaps_on && $urandom_range(99) < 34) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_item = it;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		schedule_item(it);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// random payload bits, then the controlling fields
	function automatic in_item_t make_item(logic [1:0] act, int s);
		in_item_t it;
		it = IN_W'({$urandom, $urandom});
		it.action = act;
		it.slot = s[3:0];
		return it;
	endfunction

	task automatic load_proc(int s, logic [7:0] p, logic [23:0] arr);
		in_item_t it;
		it = make_item(ACT_LOAD, s);
		it.prio = p;
		it.arrival = arr;
		send_item(it);
	endtask

	task automatic append_instr(int s, logic [15:0] d);
		in_item_t it;
		it = make_item(ACT_APPEND, s);
		it.duration = d;
		send_item(it);
	endtask

	task automatic run_round();
		send_item(make_item(ACT_ROUND, 0));
	endtask

	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (round_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, out_item);
				errors++;
			end else begin
				exp_r = round_results.pop_front();
				if (out_item !== exp_r) begin
					$display("%0t: mismatch expected %p actual %p", $time, exp_r, out_item);
					errors++;
				end
			end
		end
	end

	always @(negedge clk)
		out_stall <= gaps_on && ($urandom_range(99) < 34);

	task automatic test_directed();
		// empty table: nothing left
		run_round();
		// extremes and ties
		load_proc(0, 8'd255, 24'hFFFFFF);
		load_proc(15, 8'd0, 24'd0);
		append_instr(15, 16'hFFFF);
		append_instr(15, 16'd0);
		load_proc(3, 8'd0, 24'd0);
		append_instr(3, 16'd5);
		append_instr(7, 16'd9);            // append to empty slot
		send_item(make_item(ACT_NONE, 2)); // unknown action
		load_proc(5, 8'd10, 24'd20);       // empty program
		load_proc(3, 8'd0, 24'd100);       // reload
		append_instr(3, 16'd1);
		for (int i = 0; i < 8; i++)
			run_round();
		append_instr(15, 16'd3);           // append to done slot
		run_round();
	endtask

	task automatic test_full_program();
		load_proc(2, 8'd1, 24'd0);
		for (int i = 0; i < N_LINES + 2; i++)
			append_instr(2, 16'($urandom_range(3)));
		run_round();
		run_round();
	endtask

	task automatic test_long_programs();
		// long programs at maximum duration
		load_proc(4, 8'd2, 24'hFFFFF0);
		for (int i = 0; i < N_LINES; i++)
			append_instr(4, 16'hFFFF);
		for (int k = 0; k < 2; k++) begin
			load_proc(6, 8'd2, 24'hFFFFF0);
			for (int i = 0; i < N_LINES; i++)
				append_instr(6, 16'hFFFF);
			run_round();
			run_round();
		end
		for (int k = 0; k < 6; k++) begin
			load_proc(k % 16, 8'($urandom), 24'($urandom));
			for (int i = 0; i < 16; i++)
				append_instr(k % 16, 16'hFFFF);
			run_round();
		end
		repeat (4) run_round();
	endtask

	task automatic test_random_workloads();
		int sent;
		int n, s, t;
		logic [23:0] base;
		sent = 0;
		while (sent < 450) begin
			base = sim_clock[23:0];
			n = $urandom_range(1, 5);
			for (int p = 0; p < n; p++) begin
				s = $urandom_range(N_SLOTS - 1);
				load_proc(s, 8'($urandom_range(3)), base + 24'($urandom_range(60)));
				sent++;
				t = ($urandom_range(9) == 0) ? $urandom_range(N_LINES) : $urandom_range(5);
				for (int i = 0; i < t; i++) begin
					append_instr(s, ($urandom_range(19) == 0) ? 16'($urandom)
						: 16'($urandom_range(20)));
					sent++;
				end
			end
			n = $urandom_range(2, 10);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(9) == 0) begin
					send_item(IN_W'({$urandom, $urandom}));
				end else
					run_round();
				sent++;
			end
			if (sent > 150 && sent < 300)
				gaps_on = 0;
			else
				gaps_on = 1;
		end
	endtask

	initial begin
		errors = 0;
		cycle_count = 0;
		gaps_on = 1;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		sim_clock = 0;
		for (int s = 0; s < N_SLOTS; s++) begin
			proc_status[s] = ST_EMPTY;
			proc_prio[s] = 0;
			proc_arrival[s] = 0;
			proc_len[s] = 0;
			proc_pc[s] = 0;
			proc_busy[s] = 0;
		end
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_full_program();
		test_random_workloads();
		test_long_programs();
		wait (round_results.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
